### design/jrss_pkg.sv
// Shared types and constants for the JPEG restart strip splicer.
package jrss_pkg;

	localparam logic [7:0] MK_FF   = 8'hFF;
	localparam logic [7:0] MK_SOI  = 8'hD8;
	localparam logic [7:0] MK_SOF0 = 8'hC0;
	localparam logic [7:0] MK_SOS  = 8'hDA;
	localparam logic [7:0] MK_EOI  = 8'hD9;
	localparam logic [7:0] MK_RST0 = 8'hD0;
	localparam logic [7:0] MK_RST7 = 8'hD7;
	localparam logic [7:0] MK_ZERO = 8'h00;

	localparam logic [2:0] ST_OK       = 3'd0;
	localparam logic [2:0] ST_BAD_HDR  = 3'd1;
	localparam logic [2:0] ST_BAD_MARK = 3'd2;
	localparam logic [2:0] ST_TRUNC    = 3'd3;
	localparam logic [2:0] ST_NO_FRAME = 3'd4;

	localparam logic [2:0] HS_SOI_FF = 3'd0;
	localparam logic [2:0] HS_SOI_D8 = 3'd1;
	localparam logic [2:0] HS_SEG_FF = 3'd2;
	localparam logic [2:0] HS_CODE   = 3'd3;
	localparam logic [2:0] HS_LEN_HI = 3'd4;
	localparam logic [2:0] HS_LEN_LO = 3'd5;
	localparam logic [2:0] HS_BODY   = 3'd6;

	typedef enum logic [2:0] {
		PH_WAIT = 3'd0,
		PH_HDR  = 3'd1,
		PH_SOS  = 3'd2,
		PH_ENT  = 3'd3,
		PH_GAP  = 3'd4
	} phase_t;

	typedef struct packed {
		logic [7:0] data;
		logic       last;
		logic [2:0] status;
	} item_t;

	typedef struct packed {
		logic [2:0]      cnt;
		item_t [3:0]     items;
	} burst_t;

endpackage

### design/jpeg_restart_strip_splicer.sv
// Top level of the JPEG restart strip splicer.
//  channel | dir | request
//  s_*     | in  | one strip byte with strip flags
//  m_*     | out | one spliced stream byte or error result
//  cfg_*   | in  | full_height write
// One byte is accepted per cycle while the burst queue has room; a byte that
// yields k output bytes (k up to 4) holds the back end while they drain.
// Output goes via queue and output register. Reset clears all parse state;
// full_height resets to zero. Either side may stall without losing data.
module jpeg_restart_strip_splicer import jrss_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // data_byte
	input  logic [2:0]  s_tuser,   // strip_start, first_strip, final_strip
	input  logic        s_tlast,   // strip_end
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,   // out_byte
	output logic [2:0]  m_tuser,   // status
	output logic        m_tlast,   // out_last
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [15:0] cfg_data
);
	logic [15:0] height_q;
	logic        q_full, push, pop, head_valid;
	burst_t      push_burst, head;
	item_t       out_item;

	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) height_q <= 16'd0;
		else if (cfg_valid) height_q <= cfg_data;
	end

	jrss_front u_front (
		.clk, .arst_n,
		.in_valid(s_tvalid), .in_ready(s_tready),
		.data_byte(s_tdata), .strip_start(s_tuser[0]), .first_strip(s_tuser[1]),
		.final_strip(s_tuser[2]), .strip_end(s_tlast),
		.full_height(height_q), .q_full, .push, .push_burst
	);

	jrss_queue u_queue (
		.clk, .arst_n, .push, .push_burst, .full(q_full), .pop, .head_valid, .head
	);

	jrss_back u_back (
		.clk, .arst_n, .head_valid, .head, .pop,
		.out_valid(m_tvalid), .out_ready(m_tready), .out_item
	);

	assign m_tdata = out_item.data;
	assign m_tlast = out_item.last;
	assign m_tuser = out_item.status;
endmodule

### design/jrss_front.sv
// Front end: parses each strip byte and builds the burst of output bytes it causes.
module jrss_front import jrss_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  data_byte,
	input  logic        strip_start,
	input  logic        first_strip,
	input  logic        final_strip,
	input  logic        strip_end,
	input  logic [15:0] full_height,
	input  logic        q_full,
	output logic        push,
	output burst_t      push_burst
);
	phase_t      phase_q, nx_ph;
	logic [2:0]  hs_q, nx_hs;
	logic [15:0] rem_q, nx_rem;
	logic [2:0]  off_q, nx_off;
	logic        inf_q, nx_inf;
	logic        fs_q, nx_fs;
	logic [2:0]  rseq_q, nx_rseq;
	logic        held_q, nx_held;
	logic        pend_q, nx_pend;
	logic        first_q, nx_first;
	logic        final_q, nx_final;

	item_t [3:0] it;
	logic [2:0]  n, pre;
	logic [2:0]  err;
	logic        done, ign, busy, seg_end, bgn, bgn_first;
	logic [7:0]  emit;
	logic [15:0] len;

	assign in_ready = !q_full;
	wire acc = in_valid && in_ready;

	always_comb begin
		nx_ph = phase_q; nx_hs = hs_q; nx_rem = rem_q; nx_off = off_q; nx_inf = inf_q;
		nx_fs = fs_q; nx_rseq = rseq_q; nx_held = held_q; nx_pend = pend_q;
		nx_first = first_q; nx_final = final_q;
		it = '0; n = 3'd0; pre = 3'd0; err = ST_OK; done = 1'b0; ign = 1'b0;
		seg_end = 1'b0; emit = data_byte; len = 16'd0; bgn = 1'b0; bgn_first = 1'b0;
		busy = (phase_q == PH_HDR) || (phase_q == PH_SOS) || (phase_q == PH_ENT);
		if (strip_start) begin
			if (first_strip) begin
				if (busy || phase_q == PH_GAP) begin
					it[n[1:0]] = '{8'h00, 1'b1, ST_TRUNC}; n = n + 3'd1;
				end
				bgn = 1'b1; bgn_first = 1'b1;
			end else if (phase_q == PH_GAP) begin
				bgn = 1'b1;
			end else if (busy) begin
				it[n[1:0]] = '{8'h00, 1'b1, ST_TRUNC}; n = n + 3'd1;
				nx_ph = PH_WAIT; ign = 1'b1;
			end else begin
				ign = 1'b1;
			end
		end else if (!busy) begin
			ign = 1'b1;
		end
		if (bgn) begin
			nx_ph = PH_HDR; nx_hs = HS_SOI_FF; nx_rem = 16'd0; nx_off = 3'd0;
			nx_inf = 1'b0; nx_held = 1'b0; nx_pend = 1'b0;
			nx_first = bgn_first; nx_final = final_strip;
			if (bgn_first) begin
				nx_fs = 1'b0; nx_rseq = 3'd0;
			end
		end
		if (!ign) begin
			pre = n;
			if (nx_ph == PH_ENT) begin
				if (!nx_held) begin
					if (data_byte == MK_FF) begin
						nx_held = 1'b1;
					end else begin
						if (nx_pend) begin
							it[n[1:0]] = '{MK_FF, 1'b0, ST_OK}; n = n + 3'd1;
							it[n[1:0]] = '{MK_RST0 + {5'd0, nx_rseq}, 1'b0, ST_OK};
							n = n + 3'd1; nx_rseq = nx_rseq + 3'd1; nx_pend = 1'b0;
						end
						it[n[1:0]] = '{data_byte, 1'b0, ST_OK}; n = n + 3'd1;
					end
				end else begin
					nx_held = 1'b0;
					if (data_byte == MK_ZERO || (data_byte >= MK_RST0 && data_byte <= MK_RST7))
						begin
						if (nx_pend) begin
							it[n[1:0]] = '{MK_FF, 1'b0, ST_OK}; n = n + 3'd1;
							it[n[1:0]] = '{MK_RST0 + {5'd0, nx_rseq}, 1'b0, ST_OK};
							n = n + 3'd1; nx_rseq = nx_rseq + 3'd1; nx_pend = 1'b0;
						end
						if (data_byte == MK_ZERO) begin
							it[n[1:0]] = '{MK_FF, 1'b0, ST_OK}; n = n + 3'd1;
							it[n[1:0]] = '{MK_ZERO, 1'b0, ST_OK}; n = n + 3'd1;
						end else begin
							nx_pend = 1'b1;
						end
					end else if (data_byte == MK_EOI) begin
						nx_pend = 1'b0; done = 1'b1;
						if (nx_final) begin
							it[n[1:0]] = '{MK_FF, 1'b0, ST_OK}; n = n + 3'd1;
							it[n[1:0]] = '{MK_EOI, 1'b1, ST_OK}; n = n + 3'd1;
						end
					end else begin
						err = ST_BAD_MARK;
					end
				end
			end else begin
				case (nx_hs)
					HS_SOI_FF: begin
						if (data_byte != MK_FF) err = ST_BAD_HDR;
						else nx_hs = HS_SOI_D8;
					end
					HS_SOI_D8: begin
						if (data_byte != MK_SOI) err = ST_BAD_HDR;
						else nx_hs = HS_SEG_FF;
					end
					HS_SEG_FF: begin
						if (data_byte != MK_FF) err = ST_BAD_HDR;
						else nx_hs = HS_CODE;
					end
					HS_CODE: begin
						if (data_byte == MK_SOS) begin
							if (nx_first && !nx_fs) err = ST_NO_FRAME;
							else nx_ph = PH_SOS;
						end else if (data_byte == MK_SOF0 && nx_first) begin
							if (nx_fs) err = ST_BAD_HDR;
							else begin
								nx_fs = 1'b1; nx_inf = 1'b1; nx_off = 3'd0;
							end
						end
						nx_hs = HS_LEN_HI;
					end
					HS_LEN_HI: begin
						nx_rem = {data_byte, 8'h00};
						nx_hs = HS_LEN_LO;
					end
					HS_LEN_LO: begin
						len = {nx_rem[15:8], data_byte};
						if (len < 16'd2) err = ST_BAD_HDR;
						else if (nx_inf && len < 16'd7) err = ST_BAD_HDR;
						nx_rem = len - 16'd2;
						if (nx_rem == 16'd0) seg_end = 1'b1;
						else nx_hs = HS_BODY;
					end
					default: begin
						if (nx_inf) begin
							if (nx_off == 3'd1) emit = full_height[15:8];
							else if (nx_off == 3'd2) emit = full_height[7:0];
							if (nx_off < 3'd7) nx_off = nx_off + 3'd1;
						end
						if (nx_rem != 16'd0) nx_rem = nx_rem - 16'd1;
						if (nx_rem == 16'd0) seg_end = 1'b1;
					end
				endcase
				if (err == ST_OK) begin
					if (nx_first) begin
						it[n[1:0]] = '{emit, 1'b0, ST_OK}; n = n + 3'd1;
					end
					if (seg_end) begin
						nx_inf = 1'b0;
						if (nx_ph == PH_SOS) begin
							nx_ph = PH_ENT;
							if (!nx_first) begin
								it[n[1:0]] = '{MK_FF, 1'b0, ST_OK}; n = n + 3'd1;
								it[n[1:0]] = '{MK_RST0 + {5'd0, nx_rseq}, 1'b0, ST_OK};
								n = n + 3'd1; nx_rseq = nx_rseq + 3'd1;
							end
						end else begin
							nx_hs = HS_SEG_FF;
						end
					end
				end
			end
			if (err != ST_OK) begin
				n = pre; it[n[1:0]] = '{8'h00, 1'b1, err}; n = n + 3'd1; nx_ph = PH_WAIT;
			end else if (strip_end && !done) begin
				n = pre; it[n[1:0]] = '{8'h00, 1'b1, ST_TRUNC}; n = n + 3'd1;
				nx_ph = PH_WAIT;
			end else if (done) begin
				nx_ph = nx_final ? PH_WAIT : PH_GAP;
			end
		end
	end

	assign push = acc && (n != 3'd0);
	assign push_burst = '{n, it};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_WAIT; hs_q <= HS_SOI_FF; rem_q <= '0; off_q <= '0; inf_q <= 1'b0;
			fs_q <= 1'b0; rseq_q <= '0; held_q <= 1'b0; pend_q <= 1'b0;
			first_q <= 1'b0; final_q <= 1'b0;
		end else if (acc) begin
			phase_q <= nx_ph; hs_q <= nx_hs; rem_q <= nx_rem; off_q <= nx_off; inf_q <= nx_inf;
			fs_q <= nx_fs; rseq_q <= nx_rseq; held_q <= nx_held; pend_q <= nx_pend;
			first_q <= nx_first; final_q <= nx_final;
		end
	end
endmodule

### design/jrss_queue.sv
// Two-entry burst queue between front and back.
module jrss_queue import jrss_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   push,
	input  burst_t push_burst,
	output logic   full,
	input  logic   pop,
	output logic   head_valid,
	output burst_t head
);
	burst_t     mem_q [2];
	logic       wr_q, rd_q;
	logic [1:0] cnt_q;

	assign full = (cnt_q == 2'd2);
	assign head_valid = (cnt_q != 2'd0);
	assign head = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q] <= push_burst;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= 1'b0; rd_q <= 1'b0; cnt_q <= 2'd0;
		end else begin
			if (push) wr_q <= !wr_q;
			if (pop) rd_q <= !rd_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end
endmodule

### design/jrss_back.sv
// Back end: drains queued bursts one byte per cycle, while out_ready allows, into the output register.
module jrss_back import jrss_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   head_valid,
	input  burst_t head,
	output logic   pop,
	output logic   out_valid,
	input  logic   out_ready,
	output item_t  out_item
);
	logic [1:0] idx_q;
	logic       valid_q;
	item_t      item_q;

	wire load = head_valid && (!valid_q || out_ready);
	wire at_end = ({1'b0, idx_q} == head.cnt - 3'd1);

	assign pop = load && at_end;
	assign out_valid = valid_q;
	assign out_item = item_q;

	always_ff @(posedge clk) begin
		if (load) item_q <= head.items[idx_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= 2'd0; valid_q <= 1'b0;
		end else begin
			if (load) idx_q <= at_end ? 2'd0 : idx_q + 2'd1;
			if (load) valid_q <= 1'b1;
			else if (out_ready) valid_q <= 1'b0;
		end
	end
endmodule
